// File: hdl/lwi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwi_pkg: shared types and constants for the Lambert W iterative solver
// Q32.32 constants, status codes, sequencer states and ALU opcodes.
// ----------------------------------------------------------------------------
package lwi_pkg;

  localparam logic signed [63:0] ONE_Q   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] TWO_Q   = 64'sh0000_0002_0000_0000;
  localparam logic signed [63:0] E_Q     = 64'sh0000_0002_B7E1_5163;
  localparam logic signed [63:0] INV_E_Q = 64'sh0000_0000_5E2D_58D9;
  localparam logic signed [63:0] X_MAX_Q = 64'sh0000_0010_0000_0000;
  localparam int EXP_TERMS = 20;
  localparam logic signed [31:0] EXP_LOW  = -32'sd40;
  localparam logic signed [31:0] EXP_HIGH = 32'sd22;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_CDV = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ITER, S_EXP_TERM, S_EXP_TDIV, S_EXP_SCALE,
    S_WE, S_NUM, S_DEN_N, S_H_A, S_H_T, S_H_B, S_H_DEN, S_Q, S_WUPD,
    S_FINISH, S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: hdl/lwi_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwi_alu: shared Q32.32 multiply and divide unit
// Multiply is a shift-add on magnitudes, truncated by 32 bits and
// rounded toward zero. Divide is a restoring divider that matches
// floor(|a|*2^32/|b|). ALU_CDV divides |a| by a small integer (Taylor terms).
// ----------------------------------------------------------------------------
module lwi_alu (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire lwi_pkg::alu_req_t  req,
  input  wire  logic signed [63:0] a,
  input  wire  logic signed [63:0] b,
  output lwi_pkg::alu_rsp_t       rsp,
  output logic signed [63:0]      y
);

  logic         busy_r, busy_nxt;
  lwi_pkg::alu_op_t op_r, op_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] acc_r, acc_nxt;     // product accumulator
  logic [63:0]  ma_r, ma_nxt;       // multiplicand / dividend magnitude
  logic [63:0]  mb_r, mb_nxt;       // multiplier / divisor magnitude
  logic [63:0]  rem_r, rem_nxt;
  logic [63:0]  q_r, q_nxt;
  logic         neg_r, neg_nxt;
  logic         ovf_r, ovf_nxt;
  logic         done_r, done_nxt;
  logic signed [63:0] y_r, y_nxt;

  logic [63:0]  am, bm;
  logic [127:0] acc_add;
  logic [64:0]  rem_sh;
  logic         bit_in;
  logic [63:0]  prod_hi;

  always_comb begin
    am = a[63] ? (64'd0 - a) : a;
    bm = b[63] ? (64'd0 - b) : b;
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    y_nxt    = y_r;
    acc_add  = '0;
    rem_sh   = '0;
    bit_in   = 1'b0;
    prod_hi  = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      ma_nxt   = am;
      mb_nxt   = (req.op == lwi_pkg::ALU_CDV) ? b : bm;
      rem_nxt  = '0;
      q_nxt    = '0;
      neg_nxt  = (req.op == lwi_pkg::ALU_CDV) ? 1'b0 : (a[63] ^ b[63]);
      ovf_nxt  = (req.op != lwi_pkg::ALU_MUL) && (b == 64'sd0);
    end else if (busy_r) begin
      case (op_r)
        lwi_pkg::ALU_MUL: begin
          // one multiplier bit per cycle, LSB first
          acc_add = mb_r[cnt_r[5:0]] ? ({64'd0, ma_r} << cnt_r[5:0]) : 128'd0;
          acc_nxt = acc_r + acc_add;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            prod_hi  = acc_nxt[95:32];
            if (acc_nxt[127:95] != '0) ovf_nxt = 1'b1;
            y_nxt = neg_r ? (64'sd0 - $signed(prod_hi)) : $signed(prod_hi);
          end
        end
        lwi_pkg::ALU_DIV, lwi_pkg::ALU_CDV: begin
          if (op_r == lwi_pkg::ALU_DIV)
            bit_in = (cnt_r < 7'd64) ? ma_r[6'd63 - cnt_r[5:0]] : 1'b0;
          else
            bit_in = ma_r[6'd63 - cnt_r[5:0]];
          rem_sh = {rem_r, bit_in};
          if (op_r == lwi_pkg::ALU_DIV && q_r[62]) ovf_nxt = 1'b1;
          if (rem_sh >= {1'b0, mb_r}) begin
            rem_nxt = rem_sh[63:0] - mb_r;
            q_nxt   = {q_r[62:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[63:0];
            q_nxt   = {q_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r + 7'd1;
          if ((op_r == lwi_pkg::ALU_DIV && cnt_r == 7'd95) ||
              (op_r == lwi_pkg::ALU_CDV && cnt_r == 7'd63)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            if (q_nxt[63]) ovf_nxt = 1'b1;
            y_nxt = neg_r ? (64'sd0 - $signed(q_nxt)) : $signed(q_nxt);
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= lwi_pkg::ALU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    y_r   <= y_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign y        = y_r;

endmodule
`default_nettype wire

// File: hdl/lwi_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwi_seq: sequencer for the Newton / Halley update
// Walks exponential, multiply and divide steps through the shared ALU, does
// the add/subtract steps itself and holds the iterate and all temporaries.
// ----------------------------------------------------------------------------
module lwi_seq #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire                             halley,
  input  wire  logic signed [WORD_WIDTH-1:0] x_in,
  input  wire  logic [7:0]                iter_count,
  output logic                            idle,
  output logic                            done,
  output logic signed [WORD_WIDTH-1:0]    w_out,
  output logic [1:0]                      status_out
);

  localparam logic signed [63:0] WMAX = $signed(64'(({64{1'b1}}) >> (65 - WORD_WIDTH)));
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

  lwi_pkg::state_t state_r, state_nxt;
  lwi_pkg::alu_req_t req;
  lwi_pkg::alu_rsp_t rsp;
  logic signed [63:0] alu_a, alu_b, alu_y;

  logic signed [63:0] x_r, x_nxt, w_r, w_nxt, e_r, e_nxt, we_r, we_nxt;
  logic signed [63:0] num_r, num_nxt, den_r, den_nxt, t_r, t_nxt;
  logic signed [63:0] term_r, term_nxt, sum_r, sum_nxt;
  logic [7:0]  it_r, it_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [5:0]  sc_r, sc_nxt;     // remaining e or 1/e scalings
  logic        sneg_r, sneg_nxt;
  logic        hal_r, hal_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  st_r, st_nxt;
  logic signed [WORD_WIDTH-1:0] res_r, res_nxt;

  logic signed [64:0] s65;
  logic signed [64:0] xi_w;
  logic signed [63:0] xi;
  logic signed [63:0] n_int;
  logic signed [63:0] w_fl;

  lwi_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .a    (alu_a),
    .b    (alu_b),
    .rsp  (rsp),
    .y    (alu_y)
  );

  // input conversion into Q32.32 with clamping
  always_comb begin
    xi_w = '0;
    if (FRAC_BITS <= 32) begin
      xi_w = 65'($signed(x_in)) <<< (32 - FRAC_BITS);
      if (xi_w > 65'sh0_7FFF_FFFF_FFFF_FFFF) xi = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (xi_w < -65'sh0_7FFF_FFFF_FFFF_FFFF) xi = -64'sh7FFF_FFFF_FFFF_FFFF;
      else xi = xi_w[63:0];
    end else begin
      xi = 64'($signed(x_in) >>> (FRAC_BITS - 32));
    end
  end

  // output conversion: floor shift, then clamp check done in S_FINISH
  always_comb begin
    if (FRAC_BITS <= 32) w_fl = w_r >>> (32 - FRAC_BITS);
    else begin
      if (w_r > (64'sh7FFF_FFFF_FFFF_FFFF >>> (FRAC_BITS - 32)))
        w_fl = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (w_r < -(64'sh7FFF_FFFF_FFFF_FFFF >>> (FRAC_BITS - 32)))
        w_fl = -64'sh7FFF_FFFF_FFFF_FFFF;
      else w_fl = w_r <<< (FRAC_BITS - 32);
    end
  end

  assign n_int = w_r >>> 32;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; w_nxt = w_r; e_nxt = e_r; we_nxt = we_r;
    num_nxt = num_r; den_nxt = den_r; t_nxt = t_r;
    term_nxt = term_r; sum_nxt = sum_r;
    it_nxt = it_r; k_nxt = k_r; sc_nxt = sc_r; sneg_nxt = sneg_r;
    hal_nxt = hal_r; pend_nxt = pend_r; st_nxt = st_r; res_nxt = res_r;
    req.start = 1'b0;
    req.op = lwi_pkg::ALU_MUL;
    alu_a = '0;
    alu_b = '0;
    s65 = '0;
    case (state_r)
      lwi_pkg::S_IDLE: begin
        if (start) begin
          x_nxt = xi;
          hal_nxt = halley;
          it_nxt = iter_count;
          w_nxt = '0;
          state_nxt = lwi_pkg::S_CHECK;
        end
      end
      lwi_pkg::S_CHECK: begin
        if (x_r > lwi_pkg::X_MAX_Q) begin
          res_nxt = WORD_WIDTH'(WMAX); st_nxt = lwi_pkg::ST_DOMAIN;
          state_nxt = lwi_pkg::S_OUT;
        end else if (x_r < -lwi_pkg::INV_E_Q) begin
          res_nxt = WORD_WIDTH'(WMIN); st_nxt = lwi_pkg::ST_DOMAIN;
          state_nxt = lwi_pkg::S_OUT;
        end else state_nxt = lwi_pkg::S_ITER;
      end
      lwi_pkg::S_ITER: begin
        if (it_r == 8'd0) state_nxt = lwi_pkg::S_FINISH;
        else if (n_int >= 64'(lwi_pkg::EXP_HIGH)) state_nxt = lwi_pkg::S_WUPD;
        else if (n_int < 64'(lwi_pkg::EXP_LOW)) begin
          e_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = lwi_pkg::S_WE;
        end else begin
          // start Taylor series of e^frac
          term_nxt = lwi_pkg::ONE_Q;
          sum_nxt = lwi_pkg::ONE_Q;
          k_nxt = 6'd1;
          sneg_nxt = n_int[63];
          sc_nxt = n_int[63] ? 6'(-n_int) : 6'(n_int);
          pend_nxt = 1'b0;
          state_nxt = lwi_pkg::S_EXP_TERM;
        end
      end
      lwi_pkg::S_EXP_TERM: begin
        alu_a = term_r; alu_b = {32'd0, w_r[31:0]};
        req.op = lwi_pkg::ALU_MUL;
        if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin term_nxt = alu_y; state_nxt = lwi_pkg::S_EXP_TDIV; end
        end
      end
      lwi_pkg::S_EXP_TDIV: begin
        alu_a = term_r; alu_b = {58'd0, k_r};
        req.op = lwi_pkg::ALU_CDV;
        if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          term_nxt = alu_y;
          sum_nxt = sum_r + alu_y;
          k_nxt = k_r + 6'd1;
          if (k_r == 6'(lwi_pkg::EXP_TERMS)) state_nxt = lwi_pkg::S_EXP_SCALE;
          else state_nxt = lwi_pkg::S_EXP_TERM;
        end
      end
      lwi_pkg::S_EXP_SCALE: begin
        alu_a = sum_r; alu_b = sneg_r ? lwi_pkg::INV_E_Q : lwi_pkg::E_Q;
        req.op = lwi_pkg::ALU_MUL;
        if (sc_r == 6'd0) begin
          e_nxt = sum_r; state_nxt = lwi_pkg::S_WE;
        end else if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin sum_nxt = alu_y; sc_nxt = sc_r - 6'd1; end
        end
      end
      lwi_pkg::S_WE: begin
        alu_a = w_r; alu_b = e_r; req.op = lwi_pkg::ALU_MUL;
        if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin we_nxt = alu_y; state_nxt = lwi_pkg::S_NUM; end
        end
      end
      lwi_pkg::S_NUM: begin
        s65 = 65'(we_r) - 65'(x_r);
        num_nxt = s65[63:0];
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else if (hal_r) state_nxt = lwi_pkg::S_H_A;
        else state_nxt = lwi_pkg::S_DEN_N;
      end
      lwi_pkg::S_DEN_N: begin
        s65 = 65'(e_r) + 65'(we_r);
        den_nxt = s65[63:0];
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else state_nxt = lwi_pkg::S_Q;
      end
      lwi_pkg::S_H_A: begin
        // a = e*(w+1); w+1 cannot overflow since S_ITER keeps w below EXP_HIGH
        s65 = 65'(w_r) + 65'(lwi_pkg::ONE_Q);
        alu_a = e_r; alu_b = s65[63:0]; req.op = lwi_pkg::ALU_MUL;
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin den_nxt = alu_y; state_nxt = lwi_pkg::S_H_T; end
        end
      end
      lwi_pkg::S_H_T: begin
        s65 = 65'(w_r) + 65'(lwi_pkg::TWO_Q);
        alu_a = s65[63:0]; alu_b = num_r; req.op = lwi_pkg::ALU_MUL;
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin t_nxt = alu_y; state_nxt = lwi_pkg::S_H_B; end
        end
      end
      lwi_pkg::S_H_B: begin
        s65 = (65'(w_r) + 65'(lwi_pkg::ONE_Q)) <<< 1;
        alu_a = t_r; alu_b = s65[63:0]; req.op = lwi_pkg::ALU_DIV;
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin t_nxt = alu_y; state_nxt = lwi_pkg::S_H_DEN; end
        end
      end
      lwi_pkg::S_H_DEN: begin
        s65 = 65'(den_r) - 65'(t_r);
        den_nxt = s65[63:0];
        if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
        else state_nxt = lwi_pkg::S_Q;
      end
      lwi_pkg::S_Q: begin
        alu_a = num_r; alu_b = den_r; req.op = lwi_pkg::ALU_DIV;
        if (!pend_r) begin req.start = 1'b1; pend_nxt = 1'b1; end
        else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (rsp.ovf) state_nxt = lwi_pkg::S_WUPD;
          else begin
            s65 = 65'(w_r) - 65'(alu_y);
            if (s65[64] != s65[63]) state_nxt = lwi_pkg::S_WUPD;
            else begin
              w_nxt = s65[63:0];
              it_nxt = it_r - 8'd1;
              state_nxt = lwi_pkg::S_ITER;
            end
          end
        end
      end
      lwi_pkg::S_WUPD: begin
        // fault: saturate by the sign of the last good iterate
        res_nxt = w_r[63] ? WORD_WIDTH'(WMIN) : WORD_WIDTH'(WMAX);
        st_nxt = lwi_pkg::ST_FAULT;
        pend_nxt = 1'b0;
        state_nxt = lwi_pkg::S_OUT;
      end
      lwi_pkg::S_FINISH: begin
        if (w_fl > WMAX) begin
          res_nxt = WORD_WIDTH'(WMAX); st_nxt = lwi_pkg::ST_FAULT;
        end else if (w_fl < WMIN) begin
          res_nxt = WORD_WIDTH'(WMIN); st_nxt = lwi_pkg::ST_FAULT;
        end else begin
          res_nxt = w_fl[WORD_WIDTH-1:0]; st_nxt = lwi_pkg::ST_OK;
        end
        state_nxt = lwi_pkg::S_OUT;
      end
      lwi_pkg::S_OUT: state_nxt = lwi_pkg::S_IDLE;
      default: state_nxt = lwi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwi_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    x_r <= x_nxt; w_r <= w_nxt; e_r <= e_nxt; we_r <= we_nxt;
    num_r <= num_nxt; den_r <= den_nxt; t_r <= t_nxt;
    term_r <= term_nxt; sum_r <= sum_nxt;
    it_r <= it_nxt; k_r <= k_nxt; sc_r <= sc_nxt; sneg_r <= sneg_nxt;
    hal_r <= hal_nxt; st_r <= st_nxt; res_r <= res_nxt;
  end

  assign idle       = (state_r == lwi_pkg::S_IDLE);
  assign done       = (state_r == lwi_pkg::S_OUT);
  assign w_out      = res_r;
  assign status_out = st_r;

endmodule
`default_nettype wire

// File: hdl/lambert_w_iterative_top.sv
`default_nettype none
// Each update step runs the exponential series and its e scalings (skipped for
//   w below EXP_LOW), then 2 to 5 multiply/divide passes, repeated
//   iteration_count times; an out-of-domain x skips the iterations.
// Throughput: one item at a time, set by the shared unit; a new x waits for the last result's transfer.
// Reset: synchronous active-low rst_n; iteration_count returns to 100.
// ----------------------------------------------------------------------------
// lambert_w_iterative_top: principal-branch Lambert W by Newton or Halley
// Stream input of x and update rule, one result with W(x) and status.
// ----------------------------------------------------------------------------
module lambert_w_iterative_top #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [WORD_WIDTH-1:0]   in_tdata,   // x_value
  input  wire                     in_tuser,   // op
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [((WORD_WIDTH+2+7)/8)*8-1:0] out_tdata, // w_value, status
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [7:0]              cfg_data    // iteration_count
);

  localparam int OUT_W = ((WORD_WIDTH + 2 + 7) / 8) * 8;

  logic [7:0] iter_r;
  logic       busy_r;
  logic       ovalid_r;
  logic [OUT_W-1:0] odata_r;
  logic       seq_idle, seq_done;
  logic signed [WORD_WIDTH-1:0] seq_w;
  logic [1:0] seq_st;
  logic       in_xfer;

  assign in_tready = !busy_r && seq_idle;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lwi_seq #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .halley    (in_tuser),
    .x_in      ($signed(in_tdata)),
    .iter_count(iter_r),
    .idle      (seq_idle),
    .done      (seq_done),
    .w_out     (seq_w),
    .status_out(seq_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r   <= 8'd100;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) iter_r <= cfg_data;
      if (in_xfer) busy_r <= 1'b1;
      // hold the result until the transfer completes
      if (seq_done) ovalid_r <= 1'b1;
      else if (out_tready) begin
        ovalid_r <= 1'b0;
        if (ovalid_r) busy_r <= 1'b0;
      end
    end
    if (seq_done) odata_r <= OUT_W'({seq_st, seq_w});
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("input taken while result pending");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> busy_r) else $error("result without accepted item");
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r) else $error("busy flag not set");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for lambert_w_iterative_top
// Drives x/op transfers with random gaps, checks each W(x)/status result
// against a listed value or a bit-exact Q32.32 Newton/Halley predictor, and
// uses iteration counts of the reset value, zero, one, the maximum and small random values.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [31:0] w;
    logic [1:0]  st;
  } w_result_t;

  typedef struct {
    logic        op;
    logic [31:0] x;
    bit          typed;
    logic [31:0] w;
    logic [1:0]  st;
  } stim_row_t;

  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] X_ONE = 32'h0100_0000;
  localparam logic [31:0] X_16  = 32'h1000_0000;
  localparam logic [31:0] X_NEG_EDGE = -32'sh005E_2D58; // just inside -1/e
  localparam logic [31:0] X_NEG_OUT  = -32'sh005E_2D59; // just below -1/e
  localparam int HOLD_CYCLES = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // x_value
  logic        in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // w_value, status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;   // iteration_count

  w_result_t w_expected_q[$];
  logic [7:0] iter_count;
  int  fail_count;
  bit  idle_on;
  bit  hold_req;

  lambert_w_iterative_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Q32.32 arithmetic; each q_ function returns 0 on overflow
  // --------------------------------------------------------------------------
  function automatic logic [63:0] magnitude(input logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic bit q_add(input logic signed [63:0] a, input logic signed [63:0] b,
                               output logic signed [63:0] r);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    r = t[63:0];
    return t[64] == t[63];
  endfunction

  function automatic bit q_sub(input logic signed [63:0] a, input logic signed [63:0] b,
                               output logic signed [63:0] r);
    logic signed [64:0] t;
    t = {a[63], a} - {b[63], b};
    r = t[63:0];
    return t[64] == t[63];
  endfunction

  function automatic bit q_mul(input logic signed [63:0] a, input logic signed [63:0] b,
                               output logic signed [63:0] r);
    logic [127:0] p;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 32;
    if (p[127:63] != 0) return 0;
    r = (a[63] != b[63]) ? -p[63:0] : p[63:0];
    return 1;
  endfunction

  function automatic bit q_div(input logic signed [63:0] a, input logic signed [63:0] b,
                               output logic signed [63:0] r);
    logic [127:0] q;
    if (b == 0) return 0;
    q = {32'd0, magnitude(a), 32'd0} / {64'd0, magnitude(b)};
    if (q[127:63] != 0) return 0;
    r = (a[63] != b[63]) ? -q[63:0] : q[63:0];
    return 1;
  endfunction

  function automatic bit q_exp(input logic signed [63:0] w, output logic signed [63:0] r);
    logic signed [63:0] n, frac, sum, term, factor;
    int cnt;
    n = w >>> 32;
    frac = {32'd0, w[31:0]};
    sum = lwi_pkg::ONE_Q;
    term = lwi_pkg::ONE_Q;
    if (n >= lwi_pkg::EXP_HIGH) return 0;
    if (n < lwi_pkg::EXP_LOW) begin
      r = 0;
      return 1;
    end
    for (int k = 1; k <= lwi_pkg::EXP_TERMS; k++) begin
      if (!q_mul(term, frac, term)) return 0;
      term = term / k;
      sum = sum + term;
    end
    factor = (n >= 0) ? lwi_pkg::E_Q : lwi_pkg::INV_E_Q;
    cnt = (n >= 0) ? int'(n) : -int'(n);
    for (int i = 0; i < cnt; i++)
      if (!q_mul(sum, factor, sum)) return 0;
    r = sum;
    return 1;
  endfunction

  function automatic bit w_step(input bit halley, input logic signed [63:0] x,
                                inout logic signed [63:0] w);
    logic signed [63:0] e, we, num, den, q, w1, a, w2, t, d2, b, w_new;
    if (!q_exp(w, e) || !q_mul(w, e, we) || !q_sub(we, x, num)) return 0;
    if (!halley) begin
      if (!q_add(e, we, den)) return 0;
    end else begin
      if (!q_add(w, lwi_pkg::ONE_Q, w1) || !q_mul(e, w1, a) ||
          !q_add(w, lwi_pkg::TWO_Q, w2) ||
          !q_mul(w2, num, t) || !q_add(w1, w1, d2) || !q_div(t, d2, b) ||
          !q_sub(a, b, den))
        return 0;
    end
    // keep the last good iterate when the update fails
    if (!q_div(num, den, q) || !q_sub(w, q, w_new)) return 0;
    w = w_new;
    return 1;
  endfunction

  function automatic w_result_t lambert_predict(input logic op, input logic [31:0] x);
    w_result_t res;
    logic signed [63:0] xi, w, v;
    bit ok;
    xi = {{24{x[31]}}, x, 8'd0};
    w = 0;
    ok = 1;
    res.st = lwi_pkg::ST_OK;
    if (xi > lwi_pkg::X_MAX_Q) begin
      res.w = W_MAX;
      res.st = lwi_pkg::ST_DOMAIN;
    end else if (xi < -lwi_pkg::INV_E_Q) begin
      res.w = W_MIN;
      res.st = lwi_pkg::ST_DOMAIN;
    end else begin
      for (int i = 0; i < iter_count && ok; i++) ok = w_step(op, xi, w);
      if (!ok) begin
        res.w = w[63] ? W_MIN : W_MAX;
        res.st = lwi_pkg::ST_FAULT;
      end else begin
        v = w >>> 8;
        if (v > 64'sh7FFF_FFFF) begin
          res.w = W_MAX;
          res.st = lwi_pkg::ST_FAULT;
        end else if (v < -64'sh8000_0000) begin
          res.w = W_MIN;
          res.st = lwi_pkg::ST_FAULT;
        end else begin
          res.w = v[31:0];
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------
  task automatic send_x(input logic op, input logic [31:0] x, input bit typed,
                        input w_result_t typed_res);
    w_result_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    res = typed ? typed_res : lambert_predict(op, x);
    w_expected_q.push_back(res);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (w_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_iter_count(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iter_count = value;
  endtask

  task automatic run_rows(input stim_row_t rows[]);
    w_result_t r;
    foreach (rows[i]) begin
      r.w = rows[i].w;
      r.st = rows[i].st;
      send_x(rows[i].op, rows[i].x, rows[i].typed, r);
    end
  endtask

  function automatic logic [31:0] random_x();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return $urandom();
    if (sel < 8) return $urandom_range(0, 32'h0300_0000) - 32'h0100_0000 > X_16
                        ? X_ONE : $urandom_range(0, 32'h0200_0000);
    if (sel < 11) return -$urandom_range(0, 32'h005E_2D58);
    return $urandom_range(0, X_16);
  endfunction

  initial begin
    stim_row_t rows[];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    iter_count = 8'd100;
    fail_count = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count: only out-of-domain x, which skip the iterations
    rows = '{
      '{1'b0, 32'h7FFF_FFFF, 1, W_MAX, lwi_pkg::ST_DOMAIN},
      '{1'b1, X_16 + 1,      1, W_MAX, lwi_pkg::ST_DOMAIN},
      '{1'b0, 32'h8000_0000, 1, W_MIN, lwi_pkg::ST_DOMAIN},
      '{1'b1, X_NEG_OUT,     1, W_MIN, lwi_pkg::ST_DOMAIN},
      '{1'b0, 32'hF000_0000, 1, W_MIN, lwi_pkg::ST_DOMAIN}
    };
    run_rows(rows);
    drain_results();

    // zero iterations: w stays at the initial zero
    write_iter_count(8'd0);
    rows = '{
      '{1'b0, X_ONE,      1, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, X_16,       1, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, X_NEG_EDGE, 1, 32'd0, lwi_pkg::ST_OK}
    };
    run_rows(rows);
    drain_results();

    write_iter_count(8'd1);
    rows = '{
      '{1'b0, 32'd0,        0, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, 32'd0,        0, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, X_ONE,        0, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, X_ONE,        0, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, X_16,         0, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, X_16,         0, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, X_NEG_EDGE,   0, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, X_NEG_EDGE,   0, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, 32'hFFFF_FFFF, 0, 32'd0, lwi_pkg::ST_OK},
      '{1'b1, 32'h0280_0000, 0, 32'd0, lwi_pkg::ST_OK}
    };
    run_rows(rows);
    drain_results();

    // maximum count: one in-domain run plus fast domain rejects
    write_iter_count(8'd255);
    rows = '{
      '{1'b1, 32'd0,         1, 32'd0, lwi_pkg::ST_OK},
      '{1'b0, 32'h7FFF_FFFF, 1, W_MAX, lwi_pkg::ST_DOMAIN},
      '{1'b1, 32'h8000_0000, 1, W_MIN, lwi_pkg::ST_DOMAIN}
    };
    run_rows(rows);
    drain_results();

    // random part: small counts keep runtime in check
    for (int blk = 0; blk < 4; blk++) begin
      write_iter_count(8'($urandom_range(1, 4)));
      if (blk == 3) idle_on = 1'b0;
      for (int i = 0; i < 25; i++) begin
        if (blk == 1 && i == 3) hold_req = 1'b1;
        send_x(1'($urandom_range(0, 1)), random_x(), 0, '{default: '0});
      end
      drain_results();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  initial begin
    w_result_t exp_r;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (w_expected_q.size() == 0) begin
          $error("unexpected result transfer w_value=%h status=%0d",
                 out_tdata[31:0], out_tdata[33:32]);
          fail_count++;
        end else begin
          exp_r = w_expected_q.pop_front();
          if (out_tdata[31:0] !== exp_r.w) begin
            $error("w_value expected %h actual %h", exp_r.w, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[33:32] !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, out_tdata[33:32]);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        // hold off so the block backs up and stalls its input
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(12 * 40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
